@@ design/evip_pkg.sv @@
// Shared types and constants for the Ethernet/VLAN/IP header parser.
// No dependencies; every other design file but evip_ifs refers to it by scoped names.
package evip_pkg;

  // EtherType codes
  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_IPV6   = 16'h86DD;
  localparam logic [15:0] ETH_VLAN_C = 16'h8100;
  localparam logic [15:0] ETH_VLAN_S = 16'h88A8;

  // Header sizes in bytes
  localparam int LINK_HDR = 14;
  localparam int IPV4_HDR = 20;
  localparam int IPV6_HDR = 40;
  localparam int VLAN_TAG = 4;

  // IPv4 protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Depth of the record queue between front and back
  localparam int QDEPTH = 2;

  typedef enum logic [3:0] {
    PH_LINK  = 4'b0001,
    PH_IPV4  = 4'b0010,
    PH_IPV6  = 4'b0100,
    PH_OTHER = 4'b1000
  } evip_phase_t;

  typedef enum logic [1:0] {
    ST_SHORT   = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_IPV4    = 2'd2,
    ST_IPV6    = 2'd3
  } evip_status_t;

  typedef enum logic [1:0] {
    TK_OTHER = 2'd0,
    TK_TCP   = 2'd1,
    TK_UDP   = 2'd2,
    TK_ICMP  = 2'd3
  } evip_kind_t;

  // Per-frame summary handed from the front parser to the back end
  typedef struct packed {
    evip_phase_t phase;
    logic        link_ok;   // at least one byte past the link header
    logic        v4_ok;     // full IPv4 header after the tags
    logic        v6_ok;     // full IPv6 header after the tags
    logic [7:0]  tags;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [15:0] cap_len;
  } evip_rec_t;

endpackage

@@ design/evip_ifs.sv @@
// Channel interfaces of the header parser: byte input and result output.
// Depends on nothing; used by the top level, front and back modules.
interface evip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface evip_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  vlan_tags;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [1:0]  transport_kind;
  logic [63:0] source_high;
  logic [63:0] source_low;
  logic [15:0] captured_length;

  modport source (output valid, status, vlan_tags, ether_type, ip_protocol,
                  transport_kind, source_high, source_low, captured_length,
                  input ready);
  modport sink   (input valid, status, vlan_tags, ether_type, ip_protocol,
                  transport_kind, source_high, source_low, captured_length,
                  output ready);
endinterface

@@ design/evip_front.sv @@
// Front parser: takes one byte per cycle while the record queue is not full,
// tracks tags and headers, and emits one summary record per frame. Depends on evip_pkg and evip_in_if.
module evip_front #(
  parameter int LB = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  evip_in_if.sink             in_if,
  input  logic                q_full,
  output logic                push,
  output evip_pkg::evip_rec_t rec
);

  localparam int HW = LB + 1;   // header start can run a tag past the count
  localparam int CW = LB + 2;   // room for header start plus IPv6 header
  localparam logic [LB-1:0] LIMIT = {LB{1'b1}};

  logic [LB-1:0]         count_r, count_nxt;
  logic [15:0]           ts_r, ts_nxt;
  logic [HW-1:0]         hs_r, hs_nxt;
  evip_pkg::evip_phase_t phase_r, phase_nxt;
  logic [7:0]            tags_r, tags_nxt;
  logic [63:0]           sw0_r, sw0_nxt;
  logic [63:0]           sw1_r, sw1_nxt;
  logic [7:0]            proto_r, proto_nxt;

  logic          accept;
  logic          take;
  logic          past_hs;
  logic [HW-1:0] idx;
  logic [HW-1:0] rel;
  logic [31:0]   len32;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign push        = accept && in_if.last_byte;
  assign take        = count_r != LIMIT;
  assign idx         = HW'(count_r);
  assign past_hs     = idx >= hs_r;
  assign rel         = idx - hs_r;

  always_comb begin
    count_nxt = count_r;
    ts_nxt    = ts_r;
    hs_nxt    = hs_r;
    phase_nxt = phase_r;
    tags_nxt  = tags_r;
    sw0_nxt   = sw0_r;
    sw1_nxt   = sw1_r;
    proto_nxt = proto_r;
    if (take) begin
      count_nxt = count_r + LB'(1);
      unique case (phase_r)
        evip_pkg::PH_LINK: begin
          ts_nxt = {ts_r[7:0], in_if.data_byte};
          if (idx + HW'(1) == hs_r) begin
            if (ts_nxt == evip_pkg::ETH_VLAN_C || ts_nxt == evip_pkg::ETH_VLAN_S) begin
              if (tags_r != 8'hFF) tags_nxt = tags_r + 8'd1;
              hs_nxt = hs_r + HW'(evip_pkg::VLAN_TAG);
            end else if (ts_nxt == evip_pkg::ETH_IPV4) begin
              phase_nxt = evip_pkg::PH_IPV4;
            end else if (ts_nxt == evip_pkg::ETH_IPV6) begin
              phase_nxt = evip_pkg::PH_IPV6;
            end else begin
              phase_nxt = evip_pkg::PH_OTHER;
            end
          end
        end
        evip_pkg::PH_IPV4: begin
          if (past_hs) begin
            if (rel == HW'(9)) proto_nxt = in_if.data_byte;
            // source address: header bytes 12..15
            if (rel[HW-1:4] == '0 && rel[3:2] == 2'b11)
              sw1_nxt = {32'd0, sw1_r[23:0], in_if.data_byte};
          end
        end
        evip_pkg::PH_IPV6: begin
          if (past_hs && rel[HW-1:5] == '0) begin
            // source address: header bytes 8..23
            if (rel[4:3] == 2'b01) sw0_nxt = {sw0_r[55:0], in_if.data_byte};
            else if (rel[4:3] == 2'b10) sw1_nxt = {sw1_r[55:0], in_if.data_byte};
          end
        end
        evip_pkg::PH_OTHER: ;
        default: ;
      endcase
    end
  end

  // Frame summary, built from the values after the last byte
  assign len32 = 32'(count_nxt);

  always_comb begin
    rec.phase   = phase_nxt;
    rec.link_ok = len32 >= 32'(evip_pkg::LINK_HDR + 1);
    rec.v4_ok   = CW'(count_nxt) >= CW'(hs_nxt) + CW'(evip_pkg::IPV4_HDR);
    rec.v6_ok   = CW'(count_nxt) >= CW'(hs_nxt) + CW'(evip_pkg::IPV6_HDR);
    rec.tags    = tags_nxt;
    rec.etype   = ts_nxt;
    rec.proto   = proto_nxt;
    rec.src_hi  = sw0_nxt;
    rec.src_lo  = sw1_nxt;
    rec.cap_len = (len32 > 32'h0000_FFFF) ? 16'hFFFF : len32[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      count_r <= '0;
      ts_r    <= '0;
      hs_r    <= HW'(evip_pkg::LINK_HDR);
      phase_r <= evip_pkg::PH_LINK;
      tags_r  <= '0;
      sw0_r   <= '0;
      sw1_r   <= '0;
      proto_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
      ts_r    <= ts_nxt;
      hs_r    <= hs_nxt;
      phase_r <= phase_nxt;
      tags_r  <= tags_nxt;
      sw0_r   <= sw0_nxt;
      sw1_r   <= sw1_nxt;
      proto_r <= proto_nxt;
    end
  end

endmodule

@@ design/evip_fifo.sv @@
// Short record queue between the front parser and the back end.
// Depends on evip_pkg for the record type and depth.
module evip_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  evip_pkg::evip_rec_t wr_rec,
  input  logic                pop,
  output evip_pkg::evip_rec_t rd_rec,
  output logic                full,
  output logic                nempty
);

  localparam int AW = $clog2(evip_pkg::QDEPTH);
  localparam int NW = $clog2(evip_pkg::QDEPTH + 1);

  evip_pkg::evip_rec_t mem [evip_pkg::QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r;

  assign full   = cnt_r == NW'(evip_pkg::QDEPTH);
  assign nempty = cnt_r != '0;
  assign rd_rec = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(evip_pkg::QDEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(evip_pkg::QDEPTH - 1)) ? '0 : rp_r + AW'(1);
      if (push && !pop)      cnt_r <= cnt_r + NW'(1);
      else if (pop && !push) cnt_r <= cnt_r - NW'(1);
    end
  end

endmodule

@@ design/evip_back.sv @@
// Back end: turns a frame record into a status and result fields and
// holds them in the output register. Depends on evip_pkg and evip_out_if.
module evip_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nempty,
  input  evip_pkg::evip_rec_t q_rec,
  output logic                pop,
  evip_out_if.source          out_if
);

  logic                   out_valid_r;
  evip_pkg::evip_status_t st;
  evip_pkg::evip_kind_t   kind;

  logic [1:0]  status_r;
  logic [7:0]  tags_r;
  logic [15:0] etype_r;
  logic [7:0]  proto_r;
  logic [1:0]  kind_r;
  logic [63:0] src_hi_r, src_lo_r;
  logic [15:0] len_r;

  assign pop = q_nempty && (!out_valid_r || out_if.ready);

  always_comb begin
    priority if (!q_rec.link_ok)                               st = evip_pkg::ST_SHORT;
    else if (q_rec.phase == evip_pkg::PH_OTHER)                st = evip_pkg::ST_UNKNOWN;
    else if (q_rec.phase == evip_pkg::PH_IPV4 && q_rec.v4_ok)  st = evip_pkg::ST_IPV4;
    else if (q_rec.phase == evip_pkg::PH_IPV6 && q_rec.v6_ok)  st = evip_pkg::ST_IPV6;
    else                                                       st = evip_pkg::ST_SHORT;
  end

  always_comb begin
    priority if (q_rec.proto == evip_pkg::PROTO_TCP)  kind = evip_pkg::TK_TCP;
    else if (q_rec.proto == evip_pkg::PROTO_UDP)      kind = evip_pkg::TK_UDP;
    else if (q_rec.proto == evip_pkg::PROTO_ICMP)     kind = evip_pkg::TK_ICMP;
    else                                              kind = evip_pkg::TK_OTHER;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= st;
      len_r    <= q_rec.cap_len;
      tags_r   <= '0;
      etype_r  <= '0;
      proto_r  <= '0;
      kind_r   <= evip_pkg::TK_OTHER;
      src_hi_r <= '0;
      src_lo_r <= '0;
      unique case (st)
        evip_pkg::ST_SHORT: ;
        evip_pkg::ST_UNKNOWN: begin
          tags_r  <= q_rec.tags;
          etype_r <= q_rec.etype;
        end
        evip_pkg::ST_IPV4: begin
          tags_r   <= q_rec.tags;
          etype_r  <= q_rec.etype;
          proto_r  <= q_rec.proto;
          kind_r   <= kind;
          src_lo_r <= {32'd0, q_rec.src_lo[31:0]};
        end
        evip_pkg::ST_IPV6: begin
          tags_r   <= q_rec.tags;
          etype_r  <= q_rec.etype;
          src_hi_r <= q_rec.src_hi;
          src_lo_r <= q_rec.src_lo;
        end
        default: ;
      endcase
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = status_r;
  assign out_if.vlan_tags       = tags_r;
  assign out_if.ether_type      = etype_r;
  assign out_if.ip_protocol     = proto_r;
  assign out_if.transport_kind  = kind_r;
  assign out_if.source_high     = src_hi_r;
  assign out_if.source_low      = src_lo_r;
  assign out_if.captured_length = len_r;

endmodule

@@ design/ethernet_vlan_ip_header_parser_core.sv @@
// Top level of the Ethernet/VLAN/IP header parser.
// Depends on evip_pkg, evip_ifs, evip_front, evip_fifo and evip_back.
//
// Usage:
//   in_if  carries one frame byte per item (data_byte, last_byte); an item is
//          taken at a clock edge where valid and ready are both high.
//   out_if carries one result item per frame, emitted after the last byte.
//   The front parser takes a byte every cycle while the record queue is not
//   full, so throughput is one byte per clock with no gaps between frames,
//   even for one-byte frames. The edge that takes the last byte writes the
//   record queue; the record moves into the output register, which drives
//   out_if.valid, once that register is empty or being taken.
//   Stalls: results wait in a two-entry record queue and the output register.
//   Input ready drops only when the queue is full, i.e. after the receiver has
//   held out_if.ready low long enough for three finished frames to pile up
//   (one in the output register, two in the queue).
//   Byte counting stops at 2^LENGTH_BITS-1; later bytes are not parsed.
//   Reset (rst_n low, synchronous) clears the parser state, empties the queue
//   and drops out_if.valid; no clearing pass is needed.
module ethernet_vlan_ip_header_parser_core #(
  parameter int LENGTH_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  evip_in_if.sink     in_if,
  evip_out_if.source  out_if
);

  evip_pkg::evip_rec_t push_rec, pop_rec;
  logic push, pop, q_full, q_nempty;

  evip_front #(.LB(LENGTH_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .push   (push),
    .rec    (push_rec)
  );

  evip_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (push_rec),
    .pop    (pop),
    .rd_rec (pop_rec),
    .full   (q_full),
    .nempty (q_nempty)
  );

  evip_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_nempty (q_nempty),
    .q_rec    (pop_rec),
    .pop      (pop),
    .out_if   (out_if)
  );

`ifndef ASSERT_OFF
  // never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("record queue overflow");

  // a finished frame is in the queue on the next cycle
  a_frame_queued: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> q_nempty)
    else $error("frame record lost");

  // a too-short result carries nothing but its length
  a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status == evip_pkg::ST_SHORT) |->
      (out_if.vlan_tags == '0 && out_if.ether_type == '0 &&
       out_if.ip_protocol == '0 && out_if.source_high == '0 &&
       out_if.source_low == '0))
    else $error("too-short result has payload");

  // no result valid right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid after reset");
`endif

endmodule

@@ dv/tb_ethernet_vlan_ip_header_parser_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for ethernet_vlan_ip_header_parser_core.
// Uses evip_pkg and the evip_in_if / evip_out_if channel interfaces from the design.
module tb_ethernet_vlan_ip_header_parser_core;

  localparam int LEN_BITS     = 16;
  localparam int COUNT_LIMIT  = (1 << LEN_BITS) - 1;
  localparam int HOLD_CYCLES  = 300;        // long receiver hold-off to back up the queue
  localparam int DRAIN_CYCLES = 8;          // idle time after the last pending summary is checked
  localparam int TIMEOUT      = 2_000_000;
  localparam int DIR_ROWS     = 12;

  // One frame summary as the block reports it
  typedef struct packed {
    evip_pkg::evip_status_t status;
    logic [7:0]             tags;
    logic [15:0]            etype;
    logic [7:0]             proto;
    evip_pkg::evip_kind_t   kind;
    logic [63:0]            src_hi;
    logic [63:0]            src_lo;
    logic [15:0]            cap_len;
  } frame_summary_t;

  // Recipe for one frame: tag stack, EtherType, L3 fields, byte count.
  // Rows with typed set carry a hand-written expectation.
  typedef struct packed {
    int                     tags;
    logic [15:0]            etype;
    logic [7:0]             proto;
    logic [127:0]           src;
    int                     len;
    bit                     typed;
    evip_pkg::evip_status_t exp_status;
    logic [7:0]             exp_tags;
  } frame_spec_t;

  typedef struct packed {
    bit             typed;
    frame_summary_t summary;
  } typed_entry_t;

  logic clk;
  logic rst_n;

  evip_in_if  in_ch ();
  evip_out_if out_ch ();

  ethernet_vlan_ip_header_parser_core #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // Expected summaries, oldest first; per-frame typed overrides in send order
  frame_summary_t pending_summaries[$];
  typed_entry_t   typed_q[$];
  logic [7:0]     wire_bytes[$];
  frame_spec_t    dir_tab[DIR_ROWS];

  int fail_count;
  int frames_sent;
  int bytes_sent;
  int results_checked;
  int cycle_count;

  bit start_backlog;   // sender asks the sink for its long hold-off
  bit quiet_tail;      // no idling on either side from here on

  // Shadow parser state
  logic [15:0]           fp_count;
  logic [15:0]           fp_shift;
  int                    fp_hdr_start;
  evip_pkg::evip_phase_t fp_phase;
  logic [7:0]            fp_tags;
  logic [63:0]           fp_src_hi;
  logic [63:0]           fp_src_lo;
  logic [7:0]            fp_proto;

  function automatic void clear_parser_state();
    fp_count     = '0;
    fp_shift     = '0;
    fp_hdr_start = evip_pkg::LINK_HDR;
    fp_phase     = evip_pkg::PH_LINK;
    fp_tags      = '0;
    fp_src_hi    = '0;
    fp_src_lo    = '0;
    fp_proto     = '0;
  endfunction

  // Feed one accepted byte to the shadow parser; returns 1 with the frame
  // summary when the byte closes a frame.
  function automatic bit predict_frame_byte(input logic [7:0] b, input logic last,
                                            output frame_summary_t r);
    int idx;
    int rel;
    int len;
    idx = int'(fp_count);
    r = '0;
    // bytes past the count limit are neither counted nor parsed
    if (idx < COUNT_LIMIT) begin
      case (fp_phase)
        evip_pkg::PH_LINK: begin
          fp_shift = {fp_shift[7:0], b};
          if (idx + 1 == fp_hdr_start) begin
            if (fp_shift == evip_pkg::ETH_VLAN_C || fp_shift == evip_pkg::ETH_VLAN_S) begin
              if (fp_tags != 8'hFF) fp_tags = fp_tags + 8'd1;
              fp_hdr_start = fp_hdr_start + evip_pkg::VLAN_TAG;
            end else if (fp_shift == evip_pkg::ETH_IPV4) begin
              fp_phase = evip_pkg::PH_IPV4;
            end else if (fp_shift == evip_pkg::ETH_IPV6) begin
              fp_phase = evip_pkg::PH_IPV6;
            end else begin
              fp_phase = evip_pkg::PH_OTHER;
            end
          end
        end
        evip_pkg::PH_IPV4: begin
          if (idx >= fp_hdr_start) begin
            rel = idx - fp_hdr_start;
            if (rel == 9) fp_proto = b;
            if (rel >= 12 && rel < 16) fp_src_lo = {32'd0, fp_src_lo[23:0], b};
          end
        end
        evip_pkg::PH_IPV6: begin
          if (idx >= fp_hdr_start) begin
            rel = idx - fp_hdr_start;
            if (rel >= 8 && rel < 16) fp_src_hi = {fp_src_hi[55:0], b};
            else if (rel >= 16 && rel < 24) fp_src_lo = {fp_src_lo[55:0], b};
          end
        end
        default: ;
      endcase
      fp_count = fp_count + 16'd1;
    end
    if (!last) return 1'b0;

    len       = int'(fp_count);
    r.cap_len = fp_count;
    r.status  = evip_pkg::ST_SHORT;
    if (len >= evip_pkg::LINK_HDR + 1) begin
      if (fp_phase == evip_pkg::PH_OTHER)
        r.status = evip_pkg::ST_UNKNOWN;
      else if (fp_phase == evip_pkg::PH_IPV4 && len >= fp_hdr_start + evip_pkg::IPV4_HDR)
        r.status = evip_pkg::ST_IPV4;
      else if (fp_phase == evip_pkg::PH_IPV6 && len >= fp_hdr_start + evip_pkg::IPV6_HDR)
        r.status = evip_pkg::ST_IPV6;
    end
    if (r.status != evip_pkg::ST_SHORT) begin
      r.tags  = fp_tags;
      r.etype = fp_shift;
    end
    if (r.status == evip_pkg::ST_IPV4) begin
      r.proto  = fp_proto;
      r.src_lo = {32'd0, fp_src_lo[31:0]};
      if (fp_proto == evip_pkg::PROTO_TCP)       r.kind = evip_pkg::TK_TCP;
      else if (fp_proto == evip_pkg::PROTO_UDP)  r.kind = evip_pkg::TK_UDP;
      else if (fp_proto == evip_pkg::PROTO_ICMP) r.kind = evip_pkg::TK_ICMP;
      else                                       r.kind = evip_pkg::TK_OTHER;
    end else if (r.status == evip_pkg::ST_IPV6) begin
      r.src_hi = fp_src_hi;
      r.src_lo = fp_src_lo;
    end
    clear_parser_state();
    return 1'b1;
  endfunction

  function automatic frame_spec_t spec(int tags, logic [15:0] etype, logic [7:0] proto,
                                       logic [127:0] src, int len, bit typed,
                                       evip_pkg::evip_status_t st, logic [7:0] et);
    frame_spec_t s;
    s.tags       = tags;
    s.etype      = etype;
    s.proto      = proto;
    s.src        = src;
    s.len        = len;
    s.typed      = typed;
    s.exp_status = st;
    s.exp_tags   = et;
    return s;
  endfunction

  // Fill wire_bytes: random MACs, tag stack, EtherType, random L3 bytes with
  // protocol/source planted, then cut to the requested length.
  task automatic build_frame(input frame_spec_t s);
    int i;
    int hdr;
    logic [15:0] tpid;
    wire_bytes.delete();
    for (i = 0; i < 12; i++) wire_bytes.push_back(8'($urandom));
    for (i = 0; i < s.tags; i++) begin
      tpid = $urandom_range(0, 1) ? evip_pkg::ETH_VLAN_C : evip_pkg::ETH_VLAN_S;
      wire_bytes.push_back(tpid[15:8]);
      wire_bytes.push_back(tpid[7:0]);
      wire_bytes.push_back(8'($urandom));
      wire_bytes.push_back(8'($urandom));
    end
    wire_bytes.push_back(s.etype[15:8]);
    wire_bytes.push_back(s.etype[7:0]);
    hdr = wire_bytes.size();
    while (wire_bytes.size() < s.len) wire_bytes.push_back(8'($urandom));
    if (s.etype == evip_pkg::ETH_IPV4) begin
      if (hdr + 9 < wire_bytes.size()) wire_bytes[hdr + 9] = s.proto;
      for (i = 0; i < 4; i++)
        if (hdr + 12 + i < wire_bytes.size()) wire_bytes[hdr + 12 + i] = s.src[31 - 8*i -: 8];
    end else if (s.etype == evip_pkg::ETH_IPV6) begin
      for (i = 0; i < 16; i++)
        if (hdr + 8 + i < wire_bytes.size()) wire_bytes[hdr + 8 + i] = s.src[127 - 8*i -: 8];
    end
    while (wire_bytes.size() > s.len) void'(wire_bytes.pop_back());
  endtask

  // Offer the bytes of wire_bytes, last flag on the final one, with random gaps unless quiet_tail is set
  task automatic send_wire_bytes();
    int i;
    for (i = 0; i < wire_bytes.size(); i++) begin
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= wire_bytes[i];
      in_ch.last_byte <= (i == wire_bytes.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
    end
  endtask

  task automatic run_frame(input frame_spec_t s);
    typed_entry_t t;
    build_frame(s);
    t.typed           = s.typed;
    t.summary         = '0;
    t.summary.status  = s.exp_status;
    t.summary.cap_len = 16'((s.len > COUNT_LIMIT) ? COUNT_LIMIT : s.len);
    if (s.exp_status == evip_pkg::ST_UNKNOWN) begin
      t.summary.tags  = s.exp_tags;
      t.summary.etype = s.etype;
    end
    typed_q.push_back(t);
    frames_sent = frames_sent + 1;
    bytes_sent  = bytes_sent + wire_bytes.size();
    send_wire_bytes();
  endtask

  // Random frame: mostly well-formed, some truncated, some noise; only short lengths when tiny is set
  function automatic frame_spec_t random_spec(bit tiny);
    frame_spec_t s;
    int shape;
    int hdr;
    s = '0;
    s.src  = {$urandom, $urandom, $urandom, $urandom};
    s.tags = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: s.etype = evip_pkg::ETH_IPV4;
      5, 6, 7:       s.etype = evip_pkg::ETH_IPV6;
      default:       s.etype = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       s.proto = evip_pkg::PROTO_TCP;
      1:       s.proto = evip_pkg::PROTO_UDP;
      2:       s.proto = evip_pkg::PROTO_ICMP;
      default: s.proto = 8'($urandom);
    endcase
    hdr = evip_pkg::LINK_HDR + evip_pkg::VLAN_TAG * s.tags;
    if (s.etype == evip_pkg::ETH_IPV4)      hdr = hdr + evip_pkg::IPV4_HDR;
    else if (s.etype == evip_pkg::ETH_IPV6) hdr = hdr + evip_pkg::IPV6_HDR;
    else                                    hdr = hdr + 1;
    shape = $urandom_range(0, 9);
    if (tiny)            s.len = $urandom_range(1, 8);
    else if (shape == 0) s.len = $urandom_range(1, 30);
    else if (shape == 1) s.len = $urandom_range(1, hdr);
    else                 s.len = hdr + $urandom_range(0, 24);
    return s;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count = fail_count + 1;
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Monitor: both channels sampled at the edge with their pre-edge values.
  // Accepted bytes feed the shadow parser; accepted results are checked
  // against the oldest pending summary.
  always @(posedge clk) begin : monitor
    frame_summary_t got_sum;
    frame_summary_t want;
    typed_entry_t   t;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_summaries.size() == 0) begin
          $error("result with no frame waiting (status %0d, length %0d)",
                 out_ch.status, out_ch.captured_length);
          fail_count = fail_count + 1;
        end else begin
          want = pending_summaries.pop_front();
          check_field("status",          64'(want.status),  64'(out_ch.status));
          check_field("vlan_tags",       64'(want.tags),    64'(out_ch.vlan_tags));
          check_field("ether_type",      64'(want.etype),   64'(out_ch.ether_type));
          check_field("ip_protocol",     64'(want.proto),   64'(out_ch.ip_protocol));
          check_field("transport_kind",  64'(want.kind),    64'(out_ch.transport_kind));
          check_field("source_high",     want.src_hi,       out_ch.source_high);
          check_field("source_low",      want.src_lo,       out_ch.source_low);
          check_field("captured_length", 64'(want.cap_len), 64'(out_ch.captured_length));
          results_checked = results_checked + 1;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_frame_byte(in_ch.data_byte, in_ch.last_byte, got_sum)) begin
          // hand-typed expectation wins where the row carries one
          t = typed_q.pop_front();
          pending_summaries.push_back(t.typed ? t.summary : got_sum);
        end
      end
    end
  end

  // Result sink: random ready bursts, one long hold-off on request, then
  // steady ready for the tail.
  initial begin : result_sink
    bit hold_done;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (start_backlog && !hold_done) begin
        // long stall: finished frames pile up until input ready drops
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Stimulus and end of test
  initial begin : stimulus
    int n;
    int rand_frames;
    int tail_frames;
    fail_count       = 0;
    frames_sent      = 0;
    bytes_sent       = 0;
    results_checked  = 0;
    start_backlog    = 1'b0;
    quiet_tail       = 1'b0;
    clear_parser_state();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.last_byte  = 1'b0;

    //         tags etype                proto                src             len typed
    dir_tab[0]  = spec(0, evip_pkg::ETH_IPV4, evip_pkg::PROTO_TCP,  '0,             1,  1'b1,
                       evip_pkg::ST_SHORT,   8'd0);
    dir_tab[1]  = spec(0, evip_pkg::ETH_IPV4, evip_pkg::PROTO_TCP,  '0,             14, 1'b1,
                       evip_pkg::ST_SHORT,   8'd0);
    dir_tab[2]  = spec(0, 16'h1234,           8'd0,                 '0,             15, 1'b1,
                       evip_pkg::ST_UNKNOWN, 8'd0);
    // frame ends inside the tag chain
    dir_tab[3]  = spec(2, evip_pkg::ETH_IPV4, evip_pkg::PROTO_TCP,  '0,             20, 1'b1,
                       evip_pkg::ST_SHORT,   8'd0);
    // one byte short of a full IPv4 / IPv6 header
    dir_tab[4]  = spec(0, evip_pkg::ETH_IPV4, evip_pkg::PROTO_UDP,  '1,             33, 1'b1,
                       evip_pkg::ST_SHORT,   8'd0);
    dir_tab[5]  = spec(0, evip_pkg::ETH_IPV6, 8'd0,                 '1,             53, 1'b1,
                       evip_pkg::ST_SHORT,   8'd0);
    // exactly a full header
    dir_tab[6]  = spec(0, evip_pkg::ETH_IPV4, evip_pkg::PROTO_TCP,  '0,             34, 1'b0,
                       evip_pkg::ST_SHORT,   8'd0);
    dir_tab[7]  = spec(2, evip_pkg::ETH_IPV4, evip_pkg::PROTO_ICMP, 128'hC0A8_0001, 42, 1'b0,
                       evip_pkg::ST_SHORT,   8'd0);
    dir_tab[8]  = spec(0, evip_pkg::ETH_IPV6, 8'd0,                 '1,             54, 1'b0,
                       evip_pkg::ST_SHORT,   8'd0);
    dir_tab[9]  = spec(2, 16'h0806,           8'd0,                 '0,             30, 1'b1,
                       evip_pkg::ST_UNKNOWN, 8'd2);
    dir_tab[10] = spec(0, 16'hFFFF,           8'd0,                 '0,             15, 1'b1,
                       evip_pkg::ST_UNKNOWN, 8'd0);
    dir_tab[11] = spec(0, 16'h0000,           8'd0,                 '0,             20, 1'b1,
                       evip_pkg::ST_UNKNOWN, 8'd0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < DIR_ROWS; n++) run_frame(dir_tab[n]);

    // Random part. The first frames are tiny so the long sink hold-off
    // fills the record queue and stalls the input.
    start_backlog = 1'b1;
    rand_frames   = 0;
    while (rand_frames < 12 || bytes_sent < 360) begin
      run_frame(random_spec(rand_frames < 12));
      rand_frames = rand_frames + 1;
    end

    // tail with no idling on either side
    quiet_tail  = 1'b1;
    tail_frames = 0;
    while (tail_frames < 2 || bytes_sent < 420) begin
      run_frame(random_spec(1'b0));
      tail_frames = tail_frames + 1;
    end
    in_ch.valid     <= 1'b0;
    in_ch.last_byte <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_summaries.size() != 0) begin
      $error("%0d frame summaries never came out", pending_summaries.size());
      fail_count = fail_count + 1;
    end

    $display("Sent %0d frames / %0d bytes, checked %0d summaries.",
             frames_sent, bytes_sent, results_checked);
    $display("Covered short, unknown, IPv4 and IPv6 frames, VLAN stacks and a backed-up queue.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
